// ===== hdl/cmdsplit_pkg.sv =====
// Shared types, constants and helpers of the command line argument splitter.
package cmdsplit_pkg;

   // Longest backslash run that is held back; extra backslashes are dropped.
   localparam int MAX_RUN  = 60;
   localparam int RUN_ROOM = 60;
   localparam int RUN_CAP_RAW = (MAX_RUN > RUN_ROOM) ? RUN_ROOM : MAX_RUN;
   localparam int RUN_CAP  = (RUN_CAP_RAW < 1) ? 1 : RUN_CAP_RAW;

   // Width of the pending backslash count.
   localparam int BS_W = 6;
   localparam logic [BS_W-1:0] RUN_CAP_CNT = RUN_CAP[BS_W-1:0];

   // Command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QUEUE_PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QUEUE_CNT_W = $clog2(QUEUE_DEPTH + 1);

   // Character codes.
   localparam logic [7:0] CH_BSLASH = 8'h5C;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_VT     = 8'h0B;
   localparam logic [7:0] CH_FF     = 8'h0C;
   localparam logic [7:0] CH_CR     = 8'h0D;

   // Result kinds.
   localparam logic KIND_CHAR = 1'b0;
   localparam logic KIND_END  = 1'b1;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_type;

   typedef struct packed {
      logic       out_kind;
      logic [7:0] out_byte;
      logic       out_run_last;
      logic       out_line_end;
   } rsp_type;

   // One classified request: a run of backslashes, then an optional
   // character, then an optional argument end.
   typedef struct packed {
      logic [BS_W-1:0] bs_count;
      logic            has_char;
      logic [7:0]      char_byte;
      logic            has_end;
      logic            line_end;
   } cmd_type;

   typedef struct packed {
      logic full;
      logic not_empty;
   } queue_status_type;

   function automatic logic is_space_byte(input logic [7:0] c);
      logic result;
      case (c) inside
         CH_SPACE, CH_TAB, CH_LF, CH_VT, CH_FF, CH_CR: result = 1'b1;
         default:                                      result = 1'b0;
      endcase
      return result;
   endfunction

endpackage

// ===== hdl/cmdsplit_front.sv =====
// Front end: accepts request bytes, tracks quoting state and classifies each byte.
module cmdsplit_front (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  cmdsplit_pkg::req_type          req_data,
   input  cmdsplit_pkg::queue_status_type q_status,
   output logic                           push,
   output cmdsplit_pkg::cmd_type          push_cmd
);

   logic [cmdsplit_pkg::BS_W-1:0] bs_count_ff, bs_count_in;
   logic                          quoted_ff, quoted_in;
   logic                          prev_ws_ff, prev_ws_in;
   logic                          accept;
   logic [7:0]                    c;
   logic                          last;

   assign req_stall = q_status.full;
   assign accept    = req_valid && !q_status.full;
   assign c         = req_data.in_byte;
   assign last      = req_data.in_last;

   always_comb begin
      push_cmd           = '0;
      push_cmd.char_byte = c;
      bs_count_in        = bs_count_ff;
      quoted_in          = quoted_ff;
      prev_ws_in         = prev_ws_ff;

      if (c == cmdsplit_pkg::CH_BSLASH) begin
         if (bs_count_ff < cmdsplit_pkg::RUN_CAP_CNT) begin
            bs_count_in = bs_count_ff + 1'b1;
         end
         prev_ws_in = 1'b0;
         if (last) begin
            push_cmd.bs_count = bs_count_in;
            push_cmd.has_end  = 1'b1;
            push_cmd.line_end = 1'b1;
         end
      end else if (c == cmdsplit_pkg::CH_QUOTE) begin
         // Half the run is written either way; an odd run escapes the quote.
         push_cmd.bs_count  = bs_count_ff >> 1;
         push_cmd.has_char  = bs_count_ff[0];
         push_cmd.char_byte = cmdsplit_pkg::CH_QUOTE;
         if (!bs_count_ff[0]) begin
            quoted_in = !quoted_ff;
         end
         bs_count_in = '0;
         prev_ws_in  = 1'b0;
         if (last) begin
            push_cmd.has_end  = 1'b1;
            push_cmd.line_end = 1'b1;
         end
      end else if (cmdsplit_pkg::is_space_byte(c) && !quoted_ff) begin
         if (!prev_ws_ff) begin
            push_cmd.bs_count = bs_count_ff;
            push_cmd.has_end  = 1'b1;
            push_cmd.line_end = last;
            bs_count_in       = '0;
            prev_ws_in        = 1'b1;
         end
      end else begin
         push_cmd.bs_count = bs_count_ff;
         push_cmd.has_char = 1'b1;
         bs_count_in       = '0;
         prev_ws_in        = 1'b0;
         if (last) begin
            push_cmd.has_end  = 1'b1;
            push_cmd.line_end = 1'b1;
         end
      end

      if (last) begin
         bs_count_in = '0;
         quoted_in   = 1'b0;
         prev_ws_in  = 1'b0;
      end
   end

   // Bytes that only change state produce no command.
   assign push = accept &&
                 ((push_cmd.bs_count != '0) || push_cmd.has_char || push_cmd.has_end);

   always_ff @(posedge clock) begin
      if (reset) begin
         bs_count_ff <= '0;
         quoted_ff   <= 1'b0;
         prev_ws_ff  <= 1'b0;
      end else if (accept) begin
         bs_count_ff <= bs_count_in;
         quoted_ff   <= quoted_in;
         prev_ws_ff  <= prev_ws_in;
      end
   end

endmodule

// ===== hdl/cmdsplit_queue.sv =====
// Short command queue that decouples the front end from the result sequencer.
module cmdsplit_queue (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           push,
   input  cmdsplit_pkg::cmd_type          push_cmd,
   input  logic                           pop,
   output cmdsplit_pkg::cmd_type          head,
   output cmdsplit_pkg::queue_status_type q_status
);

   localparam int PTR_W = cmdsplit_pkg::QUEUE_PTR_W;
   localparam int CNT_W = cmdsplit_pkg::QUEUE_CNT_W;
   localparam logic [CNT_W-1:0] DEPTH_CNT = cmdsplit_pkg::QUEUE_DEPTH[CNT_W-1:0];
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(cmdsplit_pkg::QUEUE_DEPTH - 1);

   cmdsplit_pkg::cmd_type entry_ff [cmdsplit_pkg::QUEUE_DEPTH];
   logic [PTR_W-1:0]      wr_ptr_ff, rd_ptr_ff;
   logic [CNT_W-1:0]      count_ff;
   logic                  do_push, do_pop;

   assign q_status.full      = (count_ff == DEPTH_CNT);
   assign q_status.not_empty = (count_ff != '0);
   assign do_push            = push && !q_status.full;
   assign do_pop             = pop && q_status.not_empty;
   assign head               = entry_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_cmd;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
         end
         case ({do_push, do_pop})
            2'b10:   count_ff <= count_ff + 1'b1;
            2'b01:   count_ff <= count_ff - 1'b1;
            default: count_ff <= count_ff;
         endcase
      end
   end

endmodule

// ===== hdl/cmdsplit_back.sv =====
// Back end: expands queued commands into response items, one per cycle while the output is not stalled.
module cmdsplit_back (
   input  logic                           clock,
   input  logic                           reset,
   input  cmdsplit_pkg::cmd_type          head,
   input  cmdsplit_pkg::queue_status_type q_status,
   output logic                           pop,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output cmdsplit_pkg::rsp_type          rsp_data
);

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_BSLASH = 4'b0010,
      ST_CHAR   = 4'b0100,
      ST_END    = 4'b1000
   } state_type;

   state_type                     state_ff, state_in, phase;
   cmdsplit_pkg::cmd_type         cmd_ff, src;
   logic [cmdsplit_pkg::BS_W-1:0] left_ff, left_in, left;
   logic                          rsp_valid_ff;
   cmdsplit_pkg::rsp_type         rsp_ff, rsp_in;
   logic                          out_free, go, more;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign go        = out_free && ((state_ff != ST_IDLE) || q_status.not_empty);
   assign pop       = go && (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // In idle the head of the queue is worked on directly, so a single-result
   // command is popped and its response registered in the same cycle.
   always_comb begin
      if (state_ff == ST_IDLE) begin
         src  = head;
         left = head.bs_count;
         if (head.bs_count != '0) begin
            phase = ST_BSLASH;
         end else if (head.has_char) begin
            phase = ST_CHAR;
         end else begin
            phase = ST_END;
         end
      end else begin
         src   = cmd_ff;
         left  = left_ff;
         phase = state_ff;
      end
   end

   always_comb begin
      rsp_in   = '0;
      left_in  = left;
      more     = 1'b0;
      state_in = ST_IDLE;
      unique case (phase)
         ST_BSLASH: begin
            rsp_in.out_kind = cmdsplit_pkg::KIND_CHAR;
            rsp_in.out_byte = cmdsplit_pkg::CH_BSLASH;
            left_in         = left - 1'b1;
            if (left_in != '0) begin
               more     = 1'b1;
               state_in = ST_BSLASH;
            end else if (src.has_char) begin
               more     = 1'b1;
               state_in = ST_CHAR;
            end else if (src.has_end) begin
               more     = 1'b1;
               state_in = ST_END;
            end
         end
         ST_CHAR: begin
            rsp_in.out_kind = cmdsplit_pkg::KIND_CHAR;
            rsp_in.out_byte = src.char_byte;
            if (src.has_end) begin
               more     = 1'b1;
               state_in = ST_END;
            end
         end
         ST_END: begin
            rsp_in.out_kind     = cmdsplit_pkg::KIND_END;
            rsp_in.out_line_end = src.line_end;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      rsp_in.out_run_last = !more;
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cmd_ff <= head;
      end
      if (go) begin
         left_ff <= left_in;
         rsp_ff  <= rsp_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (go) begin
            state_ff <= state_in;
         end
         if (out_free) begin
            rsp_valid_ff <= go;
         end
      end
   end

endmodule

// ===== hdl/command_line_argument_splitter.sv =====
// Top level of the command line argument splitter.
//
// The splitter takes one request per cycle while req_stall is low, each one
// byte of a command line with a flag on the final byte, and returns a stream
// of responses: argument characters and argument ends. Backslash runs are held
// back until the next byte shows their meaning; before a double quote an even
// run gives half its backslashes and toggles quoting, an odd run gives half
// (rounded down) and a literal quote. Unquoted whitespace ends an argument and
// runs of whitespace collapse; pending backslashes before whitespace or at the
// line end are written out literally. Runs beyond 60 backslashes are truncated.
// The flag out_run_last marks the final response caused by each request, and
// out_line_end marks the end that closes the command line. Throughput is set
// by the response sequencer, which sends one response per cycle while
// rsp_stall is low: a request holds it until all its responses are sent, and a
// request that causes none (a backslash, an opening or closing quote, collapsed
// whitespace) does not hold it. Requests are accepted every cycle while the
// two-entry command queue between the classifier and the sequencer has room,
// so the input runs ahead by up to two commands before a slow one stalls it.
module command_line_argument_splitter (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  cmdsplit_pkg::req_type req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output cmdsplit_pkg::rsp_type rsp_data
);

   cmdsplit_pkg::queue_status_type q_status;
   cmdsplit_pkg::cmd_type          push_cmd;
   cmdsplit_pkg::cmd_type          head;
   logic                           push;
   logic                           pop;

   // The classifier owns the quoting state and turns each request into a
   // command: a backslash count, an optional character and an optional end.
   cmdsplit_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .q_status  (q_status),
      .push      (push),
      .push_cmd  (push_cmd)
   );

   // The queue lets the classifier keep taking requests while the
   // sequencer is still writing out an earlier command.
   cmdsplit_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_cmd (push_cmd),
      .pop      (pop),
      .head     (head),
      .q_status (q_status)
   );

   // The sequencer expands each command into responses through a
   // registered output stage.
   cmdsplit_back u_back (
      .clock     (clock),
      .reset     (reset),
      .head      (head),
      .q_status  (q_status),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule
